@@ rtl/hwc_pkg.sv @@
// ============================================================================
// hwc_pkg
// Shared types, constants and helpers of the hashed word counter.
// ============================================================================
package hwc_pkg;

    localparam int unsigned TABLE_SIZE_DEF = 65536;
    localparam int unsigned HASH_W         = 64;
    localparam int unsigned COUNT_W        = 32;
    localparam int unsigned BUCKET_OUT_W   = 16;
    localparam int unsigned HASH_SHIFT     = 5;
    localparam int unsigned DIGIT_W        = 4;

    localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;

    localparam logic [7:0] CHAR_TAB       = 8'd9;
    localparam logic [7:0] CHAR_CR        = 8'd13;
    localparam logic [7:0] CHAR_SPACE     = 8'd32;
    localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z   = 8'h5a;
    localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z   = 8'h7a;
    localparam logic [7:0] CASE_BIT       = 8'h20;

    // finished token heading for the bucket reduction
    typedef struct packed {
        logic              valid;
        logic [HASH_W-1:0] hash;
    } tok_item_t;

    function automatic logic is_space_byte(input logic [7:0] c);
        return ((c >= CHAR_TAB) && (c <= CHAR_CR)) || (c == CHAR_SPACE);
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z))
        begin
            return c | CASE_BIT;
        end
        return c;
    endfunction

    function automatic logic is_lower_letter(input logic [7:0] c);
        return (c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z);
    endfunction

endpackage

@@ rtl/hwc_if.sv @@
// ============================================================================
// hwc_if
// Valid/ready channels of the hashed word counter: text in, counts out.
// ============================================================================
interface hwc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface hwc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] bucket_index;
    logic [31:0] word_count;

    modport source (output valid, output bucket_index, output word_count, input ready);
    modport sink   (input valid, input bucket_index, input word_count, output ready);
endinterface

@@ rtl/hashed_word_counter.sv @@
// ============================================================================
// hashed_word_counter
// Word counter over a text byte stream with a table of hashed buckets.
// ============================================================================
// usage
//   text   : one beat per text byte, or an end-of-text beat (byte ignored)
//   result : one beat per finished token: bucket index and new bucket count
//   whitespace or end-of-text closes an open token, other bytes open one;
//   letters are folded to lower case and hashed djb2-style, others are not
// path
//   the result of a closing beat passes through 16 reduction stages
//   (one hex digit of the hash each), the memory read register and the
//   output register
// throughput (outside stalls and the clearing pass)
//   one text beat per cycle; the count memory does one read and one write
//   a cycle, with forwarding between neighbouring updates of one bucket
// reset
//   the count memory is cleared by a pass over all TABLE_SIZE entries after
//   reset, during which text.ready stays low
// stall
//   text beats keep flowing while a result waits in the output register;
//   the pipe only halts when a second result reaches the write stage
// ============================================================================
module hashed_word_counter
#(
    parameter int unsigned TABLE_SIZE = hwc_pkg::TABLE_SIZE_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    hwc_in_if.sink           text,
    hwc_out_if.source        result
);
    import hwc_pkg::*;

    localparam int unsigned ADDR_W = $clog2(TABLE_SIZE);
    localparam int unsigned EXT_W  = (ADDR_W > BUCKET_OUT_W) ? ADDR_W : BUCKET_OUT_W;

    tok_item_t          tok;
    logic               advance;
    logic               accept;
    logic               bucket_valid;
    logic [ADDR_W-1:0]  bucket;
    logic               clearing;
    logic               w_valid;
    logic [ADDR_W-1:0]  w_addr;
    logic [COUNT_W-1:0] w_count;
    logic [EXT_W-1:0]   w_addr_ext;

    logic                    out_valid_reg;
    logic [BUCKET_OUT_W-1:0] out_bucket_reg;
    logic [COUNT_W-1:0]      out_count_reg;

    // whole pipe moves unless the write stage is blocked by a waiting result
    assign advance    = !(w_valid && out_valid_reg && !result.ready);
    assign text.ready = advance && !clearing;
    assign accept     = text.valid && text.ready;

    hwc_tokenizer u_tokenizer
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .text_byte   (text.text_byte),
        .end_of_text (text.end_of_text),
        .tok         (tok)
    );

    hwc_mod_reduce
    #(
        .TABLE_SIZE (TABLE_SIZE),
        .ADDR_W     (ADDR_W)
    )
    u_mod_reduce
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .tok          (tok),
        .bucket_valid (bucket_valid),
        .bucket       (bucket)
    );

    hwc_count_ram
    #(
        .TABLE_SIZE (TABLE_SIZE),
        .ADDR_W     (ADDR_W)
    )
    u_count_ram
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .req_valid (bucket_valid),
        .req_addr  (bucket),
        .clearing  (clearing),
        .w_valid   (w_valid),
        .w_addr    (w_addr),
        .w_count   (w_count)
    );

    // only the low 16 bits of the bucket go out
    assign w_addr_ext = EXT_W'(w_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && w_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && w_valid)
        begin
            out_bucket_reg <= w_addr_ext[BUCKET_OUT_W-1:0];
            out_count_reg  <= w_count;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.bucket_index = out_bucket_reg;
    assign result.word_count   = out_count_reg;

endmodule

@@ rtl/hwc_tokenizer.sv @@
// ============================================================================
// hwc_tokenizer
// Splits the byte stream into tokens and keeps the running djb2 hash.
// ============================================================================
module hwc_tokenizer
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         text_byte,
    input  logic               end_of_text,
    output hwc_pkg::tok_item_t tok
);
    import hwc_pkg::*;

    logic              in_token_reg;
    logic              in_token_next;
    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;
    logic [HASH_W-1:0] hash_base;
    logic [7:0]        folded;
    logic              closing;

    assign closing = end_of_text || is_space_byte(text_byte);
    assign folded  = fold_case(text_byte);

    always_comb
    begin
        in_token_next = in_token_reg;
        hash_next     = hash_reg;
        hash_base     = in_token_reg ? hash_reg : HASH_SEED;
        if (accept)
        begin
            if (closing)
            begin
                in_token_next = 1'b0;
                hash_next     = HASH_SEED;
            end
            else
            begin
                in_token_next = 1'b1;
                if (is_lower_letter(folded))
                begin
                    hash_next = (hash_base << HASH_SHIFT) + hash_base + HASH_W'(folded);
                end
                else
                begin
                    hash_next = hash_base;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_token_reg <= 1'b0;
            hash_reg     <= HASH_SEED;
        end
        else
        begin
            in_token_reg <= in_token_next;
            hash_reg     <= hash_next;
        end
    end

    // a token closes on whitespace or end marker only when one is open
    assign tok.valid = accept && closing && in_token_reg;
    assign tok.hash  = hash_reg;

endmodule

@@ rtl/hwc_mod_reduce.sv @@
// ============================================================================
// hwc_mod_reduce
// Pipelined hash modulo table size, one hex digit of the hash per stage.
// ============================================================================
module hwc_mod_reduce
#(
    parameter int unsigned TABLE_SIZE = hwc_pkg::TABLE_SIZE_DEF,
    parameter int unsigned ADDR_W     = $clog2(hwc_pkg::TABLE_SIZE_DEF)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  hwc_pkg::tok_item_t tok,
    output logic               bucket_valid,
    output logic [ADDR_W-1:0]  bucket
);
    import hwc_pkg::*;

    localparam int unsigned DIGITS = HASH_W / DIGIT_W;
    localparam int unsigned VW     = ADDR_W + DIGIT_W;
    localparam int unsigned RADIX  = 1 << DIGIT_W;

    logic              valid_reg [DIGITS];
    logic [ADDR_W-1:0] rem_reg   [DIGITS];
    logic [HASH_W-1:0] hash_reg  [DIGITS-1];

    // (rem * radix + digit) mod table size; rem < table size keeps the quotient below radix
    function automatic logic [ADDR_W-1:0] digit_step(input logic [ADDR_W-1:0] rem,
                                                     input logic [DIGIT_W-1:0] dig);
        logic [VW-1:0] v;
        logic [VW-1:0] r;
        v = {rem, dig};
        r = v;
        for (int k = 1; k < RADIX; k++)
        begin
            if (v >= VW'(k * TABLE_SIZE))
            begin
                r = v - VW'(k * TABLE_SIZE);
            end
        end
        return r[ADDR_W-1:0];
    endfunction

    for (genvar s = 0; s < DIGITS; s++)
    begin : g_stage
        logic              src_valid;
        logic [ADDR_W-1:0] src_rem;
        logic [HASH_W-1:0] src_hash;

        if (s == 0)
        begin : g_first
            assign src_valid = tok.valid;
            assign src_rem   = '0;
            assign src_hash  = tok.hash;
        end
        else
        begin : g_next
            assign src_valid = valid_reg[s-1];
            assign src_rem   = rem_reg[s-1];
            assign src_hash  = hash_reg[s-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[s] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[s] <= digit_step(src_rem, src_hash[HASH_W-1 -: DIGIT_W]);
            end
        end

        if (s < DIGITS - 1)
        begin : g_shift
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    hash_reg[s] <= src_hash << DIGIT_W;
                end
            end
        end
    end

    assign bucket_valid = valid_reg[DIGITS-1];
    assign bucket       = rem_reg[DIGITS-1];

endmodule

@@ rtl/hwc_count_ram.sv @@
// ============================================================================
// hwc_count_ram
// Bucket count memory: clearing pass, read-modify-write with forwarding.
// ============================================================================
module hwc_count_ram
#(
    parameter int unsigned TABLE_SIZE = hwc_pkg::TABLE_SIZE_DEF,
    parameter int unsigned ADDR_W     = $clog2(hwc_pkg::TABLE_SIZE_DEF)
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        req_valid,
    input  logic [ADDR_W-1:0]           req_addr,
    output logic                        clearing,
    output logic                        w_valid,
    output logic [ADDR_W-1:0]           w_addr,
    output logic [hwc_pkg::COUNT_W-1:0] w_count
);
    import hwc_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_SIZE - 1);

    logic [COUNT_W-1:0] mem [TABLE_SIZE];

    logic               clear_active_reg;
    logic [ADDR_W-1:0]  clear_addr_reg;
    logic               w_valid_reg;
    logic [ADDR_W-1:0]  w_addr_reg;
    logic [COUNT_W-1:0] rd_data_reg;
    logic               last_valid_reg;
    logic [ADDR_W-1:0]  last_addr_reg;
    logic [COUNT_W-1:0] last_count_reg;

    logic               forward;
    logic [COUNT_W-1:0] base_count;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [COUNT_W-1:0] wr_data;

    // clearing pass after reset, one entry a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
        end
        else if (clear_active_reg)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == LAST_ADDR)
            begin
                clear_active_reg <= 1'b0;
            end
        end
    end

    // write of the previous beat lands at the edge this one is read
    assign forward    = last_valid_reg && (last_addr_reg == w_addr_reg);
    assign base_count = forward ? last_count_reg : rd_data_reg;
    assign w_count    = (base_count == '1) ? base_count : base_count + 1'b1;

    always_comb
    begin
        if (clear_active_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clear_addr_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = advance && w_valid_reg;
            wr_addr = w_addr_reg;
            wr_data = w_count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (advance && req_valid)
        begin
            rd_data_reg <= mem[req_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg    <= 1'b0;
            last_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            w_valid_reg    <= req_valid;
            last_valid_reg <= w_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            w_addr_reg     <= req_addr;
            last_addr_reg  <= w_addr_reg;
            last_count_reg <= w_count;
        end
    end

    assign clearing = clear_active_reg;
    assign w_valid  = w_valid_reg;
    assign w_addr   = w_addr_reg;

endmodule

@@ tb/hwc_count_checker.sv @@
`timescale 1ns / 100ps
// ============================================================================
// hwc_count_checker
// Watches the text and result channels, keeps its own copy of the open
// token, its hash and the bucket counts, and checks every result beat
// against the oldest predicted bucket update.
// ============================================================================
module hwc_count_checker
#(
    parameter int unsigned TABLE_SIZE = hwc_pkg::TABLE_SIZE_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    hwc_in_if    text,
    hwc_out_if   result,
    output int   mismatch_count,
    output int   counts_pending
);
    import hwc_pkg::*;

    typedef struct packed {
        logic [BUCKET_OUT_W-1:0] bucket;
        logic [COUNT_W-1:0]      count;
    } bucket_update_t;

    bucket_update_t     expected_updates[$];
    bucket_update_t     seen_update;
    logic               open_token = 1'b0;
    logic [HASH_W-1:0]  word_hash  = HASH_SEED;
    bit   [COUNT_W-1:0] bucket_tally [TABLE_SIZE];
    int                 mismatches = 0;

    assign mismatch_count = mismatches;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
        mismatches++;
    endtask

    // one accepted text beat: may close a token and yield one bucket update
    task automatic count_text_beat(input logic [7:0] b, input logic eot);
        logic [7:0]     c;
        int unsigned    slot;
        bucket_update_t upd;
        c = b;
        if (eot || ((c >= CHAR_TAB) && (c <= CHAR_CR)) || (c == CHAR_SPACE))
        begin
            if (open_token)
            begin
                slot = int'(word_hash % 64'(TABLE_SIZE));
                if (bucket_tally[slot] != {COUNT_W{1'b1}})
                begin
                    bucket_tally[slot]++;
                end
                upd.bucket = slot[BUCKET_OUT_W-1:0];
                upd.count  = bucket_tally[slot];
                expected_updates.push_back(upd);
                open_token = 1'b0;
                word_hash  = HASH_SEED;
            end
        end
        else
        begin
            if (!open_token)
            begin
                open_token = 1'b1;
                word_hash  = HASH_SEED;
            end
            if ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z))
            begin
                c = c + (CHAR_LOWER_A - CHAR_UPPER_A);
            end
            if ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z))
            begin
                word_hash = (word_hash << HASH_SHIFT) + word_hash + {56'd0, c};
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (text.valid && text.ready)
            begin
                count_text_beat(text.text_byte, text.end_of_text);
            end
            if (result.valid && result.ready)
            begin
                if (expected_updates.size() == 0)
                begin
                    report_mismatch("result beat with no token closed, bucket", 0,
                                    32'(result.bucket_index));
                end
                else
                begin
                    seen_update = expected_updates.pop_front();
                    if (result.bucket_index !== seen_update.bucket)
                    begin
                        report_mismatch("bucket_index", 32'(seen_update.bucket),
                                        32'(result.bucket_index));
                    end
                    if (result.word_count !== seen_update.count)
                    begin
                        report_mismatch("word_count", seen_update.count,
                                        result.word_count);
                    end
                end
            end
        end
        counts_pending <= expected_updates.size();
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Word counter regression: directed tokens covering case folding, dropped
// bytes, letterless tokens and a bucket collision, then random text in three
// idling phases with a long output hold-off; the checker does the scoring.
// ============================================================================
module testbench;
    import hwc_pkg::*;

    localparam int POOL_WORDS = 10;
    localparam int POOL_CHARS = 12;
    localparam int LONG_HOLD  = 300;   // cycles of result stall to back the pipe up
    localparam int DRAIN_WAIT = 40;    // well past the result latency

    logic clk;
    logic rst_n;
    logic hold_req;

    int tx_idle_pct;
    int rx_idle_pct;
    int beats_sent;
    int mismatch_count;
    int counts_pending;

    // small vocabulary so that buckets get counted up more than once
    logic [7:0] pool_chars [POOL_WORDS][POOL_CHARS];
    int         pool_len   [POOL_WORDS];

    hwc_in_if  text_ch ();
    hwc_out_if result_ch ();

    hashed_word_counter u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .result (result_ch)
    );

    hwc_count_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .text           (text_ch),
        .result         (result_ch),
        .mismatch_count (mismatch_count),
        .counts_pending (counts_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit, allowing for the clearing pass after reset
    initial
    begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

    // result side: random stalls, plus one long hold-off when asked for
    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // offer one text beat, idling first at random, and wait until it is taken
    task automatic send_beat(input logic [7:0] b, input logic eot);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            text_ch.valid <= 1'b0;
            @(posedge clk);
        end
        text_ch.valid       <= 1'b1;
        text_ch.text_byte   <= b;
        text_ch.end_of_text <= eot;
        @(posedge clk);
        while (!text_ch.ready)
        begin
            @(posedge clk);
        end
        beats_sent++;
    endtask

    task automatic send_chars(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_beat(s[i], 1'b0);
        end
    endtask

    // drop valid and hold off until every predicted update has come back
    task automatic wait_counts_drained();
        text_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (counts_pending != 0);
    endtask

    // random text: mostly words with separators, some stray bytes and markers
    task automatic send_random_text(input int n_beats);
        int         stop_at;
        int         pick;
        int         len;
        logic [7:0] c;
        stop_at = beats_sent + n_beats;
        while (beats_sent < stop_at)
        begin
            if ($urandom_range(99) < 80)
            begin
                pick = $urandom_range(2 * POOL_WORDS - 1);
                if (pick < POOL_WORDS)
                begin
                    // known word, random letter case
                    for (int i = 0; i < pool_len[pick]; i++)
                    begin
                        c = pool_chars[pick][i];
                        if ($urandom_range(1) == 1)
                        begin
                            c = c & ~CASE_BIT;
                        end
                        send_beat(c, 1'b0);
                    end
                end
                else
                begin
                    // fresh word, now and then a long one that wraps the hash
                    len = ($urandom_range(9) == 0) ? $urandom_range(14, 32)
                                                   : $urandom_range(1, 8);
                    for (int i = 0; i < len; i++)
                    begin
                        if ($urandom_range(99) < 85)
                        begin
                            c = 8'($urandom_range(25)) +
                                (($urandom_range(1) == 1) ? CHAR_UPPER_A : CHAR_LOWER_A);
                        end
                        else
                        begin
                            c = 8'($urandom_range(255));
                        end
                        send_beat(c, 1'b0);
                    end
                end
                // closing separator: whitespace or end-of-text with junk byte
                if ($urandom_range(99) < 85)
                begin
                    c = ($urandom_range(5) == 5) ? CHAR_SPACE
                                                 : CHAR_TAB + 8'($urandom_range(4));
                    send_beat(c, 1'b0);
                end
                else
                begin
                    send_beat(8'($urandom_range(255)), 1'b1);
                end
            end
            else
            begin
                // stray beat: any byte, sometimes an end marker
                send_beat(8'($urandom_range(255)), $urandom_range(3) == 0);
            end
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        hold_req            <= 1'b0;
        text_ch.valid       <= 1'b0;
        text_ch.text_byte   <= 8'h00;
        text_ch.end_of_text <= 1'b0;
        tx_idle_pct         = 12;
        rx_idle_pct         = 48;
        beats_sent          = 0;
        for (int p = 0; p < POOL_WORDS; p++)
        begin
            pool_len[p] = $urandom_range(1, POOL_CHARS);
            for (int i = 0; i < POOL_CHARS; i++)
            begin
                pool_chars[p][i] = CHAR_LOWER_A + 8'($urandom_range(25));
            end
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // letter extremes, digit and top byte dropped inside a token, tab ends it
        send_beat(CHAR_UPPER_A, 1'b0);
        send_beat(CHAR_LOWER_Z, 1'b0);
        send_beat(8'h37, 1'b0);
        send_beat(8'hff, 1'b0);
        send_beat(CHAR_TAB, 1'b0);
        // other extremes, null byte dropped, carriage return ends it
        send_beat(CHAR_UPPER_Z, 1'b0);
        send_beat(CHAR_LOWER_A, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(CHAR_CR, 1'b0);
        // letterless token of bytes just outside the letter and space ranges, form feed ends it
        send_chars("@[`{");
        send_beat(8'd8, 1'b0);
        send_beat(8'd14, 1'b0);
        send_beat(8'd12, 1'b0);
        // end marker with nothing open: no result, byte ignored
        send_beat(8'h78, 1'b1);
        // two distinct words whose hashes differ by exactly 65536: same bucket
        send_chars("amam");
        send_beat(8'd10, 1'b0);
        send_chars("cggk");
        send_beat(8'h55, 1'b1);
        // whitespace with no open token
        send_beat(8'd11, 1'b0);

        send_random_text(400);
        wait_counts_drained();

        tx_idle_pct = 48;
        rx_idle_pct = 12;
        send_random_text(400);
        wait_counts_drained();

        // no idling; result side stalls long enough to back the pipe up
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    <= 1'b1;
        send_random_text(420);
        wait_counts_drained();

        repeat (DRAIN_WAIT) @(posedge clk);
        if ((mismatch_count == 0) && (counts_pending == 0))
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
